// ----- src/tpved_pkg.sv -----
// Shared constants, codes and types of the three-phase voltage event detector.
package tpved_pkg;

   localparam int NUM_PHASES = 3;
   localparam int NUM_SLOTS  = 2 * NUM_PHASES + 1;

   localparam int COND_W = 3;
   localparam int VOLT_W = 16;
   localparam int CODE_W = 4;
   localparam int IMB_W  = 16;

   // Request packing: conditions first, then voltages, then imbalance.
   localparam int REQ_VOLT_OFS = NUM_PHASES * COND_W;
   localparam int REQ_IMB_OFS  = REQ_VOLT_OFS + NUM_PHASES * VOLT_W;
   localparam int REQ_USED_W   = REQ_IMB_OFS + IMB_W;
   localparam int REQ_TDATA_W  = ((REQ_USED_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_USED_W   = CODE_W + VOLT_W;
   localparam int RSP_TDATA_W  = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_USED_W;

   localparam logic [IMB_W-1:0] IMB_LIMIT_RESET = 16'd500;

   // Phase condition codes
   localparam logic [COND_W-1:0] COND_UNKNOWN = 3'd0;
   localparam logic [COND_W-1:0] COND_LOST    = 3'd2;
   localparam logic [COND_W-1:0] COND_UNDER   = 3'd3;
   localparam logic [COND_W-1:0] COND_OVER    = 3'd4;

   // Event codes
   localparam logic [CODE_W-1:0] EV_LOST_BASE     = 4'd0;
   localparam logic [CODE_W-1:0] EV_RESTORED_BASE = 4'd3;
   localparam logic [CODE_W-1:0] EV_UNDER         = 4'd6;
   localparam logic [CODE_W-1:0] EV_UNDER_CLR     = 4'd7;
   localparam logic [CODE_W-1:0] EV_OVER          = 4'd8;
   localparam logic [CODE_W-1:0] EV_OVER_CLR      = 4'd9;
   localparam logic [CODE_W-1:0] EV_IMB           = 4'd10;
   localparam logic [CODE_W-1:0] EV_IMB_CLR       = 4'd11;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [VOLT_W-1:0] value;
   } event_type;

   // Up to two ordered events of one phase; vld[0] marks the first.
   typedef struct packed {
      logic [1:0]      vld;
      event_type [1:0] ev;
   } phase_ev_type;

endpackage

// ----- src/three_phase_voltage_event_detector.sv -----
// Top level of the three-phase voltage event detector.
//
// Usage
//   req_ channel: one three-phase snapshot per transaction. A snapshot with
//   reading_valid low is taken and dropped without events or state change.
//   rsp_ channel: the events of a snapshot, one per transaction, phases in
//   order A, B, C and then the imbalance event; rsp_tlast marks the final
//   event of a snapshot. A snapshot that causes no event produces nothing.
//   csr_ port: writes imbalance_limit; always ready. Write it only while
//   the block is idle.
// Event flow
//   The first event of a snapshot appears after the input register and the
//   event list. A snapshot yields up to seven events; the single event list
//   drains one event per cycle while rsp_tready is high.
// Reset
//   Synchronous reset empties both stages, forgets every phase condition
//   (unknown), clears the imbalance flag and sets the limit to 500.
// Stalls
//   When rsp_tready is low the current event holds; one further snapshot
//   waits in the input register, after which req_tready drops.
module three_phase_voltage_event_detector
   import tpved_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // cond_a[2:0], cond_b[5:3], cond_c[8:6], volt_a[24:9], volt_b[40:25],
   // volt_c[56:41], imbalance_value[72:57], zero fill [79:73]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // reading_valid[0], imbalance_known[1]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // event_code[3:0], event_value[19:4], zero fill [23:20]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [IMB_W-1:0]       csr_data,
   input  logic                   csr_valid,
   output logic                   csr_ready
);

   // Input register
   logic                   in_valid_ff, in_valid_in;
   logic [REQ_TDATA_W-1:0] in_data_ff, in_data_in;
   logic [REQ_TUSER_W-1:0] in_user_ff, in_user_in;

   // Event list: fixed slots, two per phase and one for imbalance
   logic [NUM_SLOTS-1:0]   pend_ff, pend_in;
   event_type              slot_ff [NUM_SLOTS];
   event_type              slot_in [NUM_SLOTS];

   // Detector state and limit register
   logic [COND_W-1:0]      prior_ff [NUM_PHASES];
   logic [COND_W-1:0]      prior_in [NUM_PHASES];
   logic                   imb_flag_ff, imb_flag_in;
   logic [IMB_W-1:0]       limit_ff, limit_in;

   logic [NUM_SLOTS-1:0]   pop_onehot;
   logic [NUM_SLOTS-1:0]   pend_left;
   logic [NUM_SLOTS-1:0]   new_pend;
   logic                   pop;
   logic                   load;
   logic                   commit;
   logic                   req_acc;
   logic                   rd_valid;
   logic                   imb_known;
   logic [IMB_W-1:0]       imb_raw;
   logic [IMB_W-1:0]       imb_val;
   logic                   now_imb;
   logic                   imb_evt;
   event_type              imb_ev;
   event_type              rsp_ev;
   logic [COND_W-1:0]      cond_after [NUM_PHASES];
   logic [VOLT_W-1:0]      volt [NUM_PHASES];
   phase_ev_type           ph_ev [NUM_PHASES];

   // Drain: the lowest pending slot is the next event
   assign pop_onehot = pend_ff & (~pend_ff + 1'b1);
   assign rsp_tvalid = |pend_ff;
   assign rsp_tlast  = (pend_ff == pop_onehot);
   assign pop        = rsp_tvalid && rsp_tready;
   assign pend_left  = pop ? (pend_ff & ~pop_onehot) : pend_ff;

   // Advance the held snapshot into the list once the list empties
   assign load       = in_valid_ff && (pend_left == '0);
   assign req_tready = !in_valid_ff || load;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      rsp_ev = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (pop_onehot[i]) begin
            rsp_ev = rsp_ev | slot_ff[i];
         end
      end
   end

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_ev.value, rsp_ev.code};

   // Unpack the held snapshot
   assign rd_valid  = in_user_ff[0];
   assign imb_known = in_user_ff[1];
   assign imb_raw   = in_data_ff[REQ_IMB_OFS +: IMB_W];

   for (genvar p = 0; p < NUM_PHASES; p++) begin : g_phase
      assign cond_after[p] = in_data_ff[COND_W * p +: COND_W];
      assign volt[p]       = in_data_ff[REQ_VOLT_OFS + VOLT_W * p +: VOLT_W];

      tpved_phase_events u_phase (
         .cond_before (prior_ff[p]),
         .cond_after  (cond_after[p]),
         .volt        (volt[p]),
         .phase_index (2'(p)),
         .phase_ev    (ph_ev[p])
      );
   end

   // An imbalance that is not a number counts as balanced, value zero
   assign imb_val = imb_known ? imb_raw : '0;
   assign now_imb = imb_known && (imb_raw > limit_ff);
   assign imb_evt = (now_imb != imb_flag_ff);
   assign imb_ev  = '{code: (now_imb ? EV_IMB : EV_IMB_CLR), value: imb_val};
   assign commit  = load && rd_valid;

   always_comb begin
      new_pend = '0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         new_pend[2 * p +: 2] = ph_ev[p].vld;
      end
      new_pend[NUM_SLOTS-1] = imb_evt;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_acc) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
      in_data_in = req_acc ? req_tdata : in_data_ff;
      in_user_in = req_acc ? req_tuser : in_user_ff;

      pend_in = load ? (rd_valid ? new_pend : '0) : pend_left;
      for (int p = 0; p < NUM_PHASES; p++) begin
         slot_in[2 * p]     = load ? ph_ev[p].ev[0] : slot_ff[2 * p];
         slot_in[2 * p + 1] = load ? ph_ev[p].ev[1] : slot_ff[2 * p + 1];
         prior_in[p]        = commit ? cond_after[p] : prior_ff[p];
      end
      slot_in[NUM_SLOTS-1] = load ? imb_ev : slot_ff[NUM_SLOTS-1];
      imb_flag_in = commit ? now_imb : imb_flag_ff;
      limit_in    = (csr_valid && csr_ready) ? csr_data : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pend_ff     <= '0;
         imb_flag_ff <= 1'b0;
         limit_ff    <= IMB_LIMIT_RESET;
         for (int p = 0; p < NUM_PHASES; p++) begin
            prior_ff[p] <= COND_UNKNOWN;
         end
      end else begin
         in_valid_ff <= in_valid_in;
         pend_ff     <= pend_in;
         imb_flag_ff <= imb_flag_in;
         limit_ff    <= limit_in;
         for (int p = 0; p < NUM_PHASES; p++) begin
            prior_ff[p] <= prior_in[p];
         end
      end
   end

   // Payload: no reset
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      in_user_ff <= in_user_in;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

// ----- src/tpved_phase_events.sv -----
// Event decode of one phase: leave and entry events in emission order.
module tpved_phase_events
   import tpved_pkg::*;
(
   input  logic [COND_W-1:0] cond_before,
   input  logic [COND_W-1:0] cond_after,
   input  logic [VOLT_W-1:0] volt,
   input  logic [1:0]        phase_index,
   output phase_ev_type      phase_ev
);

   logic              changed;
   logic              from_unknown;
   logic              leave_vld;
   logic              enter_vld;
   logic [2:0]        leave_rank;
   logic [2:0]        enter_rank;
   logic [CODE_W-1:0] leave_code;
   logic [CODE_W-1:0] enter_code;
   logic              leave_first;
   event_type         leave_ev;
   event_type         enter_ev;

   assign changed      = (cond_before != cond_after);
   assign from_unknown = (cond_before == COND_UNKNOWN);

   // Rank follows the emission order: restored, lost, under cleared,
   // under, over cleared, over.
   always_comb begin
      leave_vld  = 1'b0;
      leave_rank = 3'd0;
      leave_code = EV_UNDER_CLR;
      unique case (cond_before)
         COND_LOST: begin
            leave_vld  = 1'b1;
            leave_rank = 3'd0;
            leave_code = EV_RESTORED_BASE + {2'b00, phase_index};
         end
         COND_UNDER: begin
            leave_vld  = 1'b1;
            leave_rank = 3'd2;
            leave_code = EV_UNDER_CLR;
         end
         COND_OVER: begin
            leave_vld  = 1'b1;
            leave_rank = 3'd4;
            leave_code = EV_OVER_CLR;
         end
         default: begin
         end
      endcase
      leave_vld = leave_vld && changed && !from_unknown;
   end

   always_comb begin
      enter_vld  = 1'b0;
      enter_rank = 3'd1;
      enter_code = EV_UNDER;
      unique case (cond_after)
         COND_LOST: begin
            enter_vld  = 1'b1;
            enter_rank = 3'd1;
            enter_code = EV_LOST_BASE + {2'b00, phase_index};
         end
         COND_UNDER: begin
            enter_vld  = 1'b1;
            enter_rank = 3'd3;
            enter_code = EV_UNDER;
         end
         COND_OVER: begin
            enter_vld  = 1'b1;
            enter_rank = 3'd5;
            enter_code = EV_OVER;
         end
         default: begin
         end
      endcase
      enter_vld = enter_vld && changed;
   end

   assign leave_ev    = '{code: leave_code, value: volt};
   assign enter_ev    = '{code: enter_code, value: volt};
   assign leave_first = leave_vld && (!enter_vld || (leave_rank < enter_rank));

   always_comb begin
      phase_ev.vld = {leave_vld && enter_vld, leave_vld || enter_vld};
      if (leave_first) begin
         phase_ev.ev[0] = leave_ev;
         phase_ev.ev[1] = enter_ev;
      end else begin
         phase_ev.ev[0] = enter_ev;
         phase_ev.ev[1] = leave_ev;
      end
   end

endmodule

// ----- src/tpved_checker.sv -----
// Port-level checks of the three-phase voltage event detector, bound to the top level.
module tpved_checker
   import tpved_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready
);

   // Both stages empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not empty after reset");

   // A stalled event holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled event changed");

   // Only defined event codes, zero fill clear
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[CODE_W-1:0] <= EV_IMB_CLR) &&
                      (rsp_tdata[RSP_TDATA_W-1:RSP_USED_W] == '0)))
      else $error("undefined event code or fill bits set");

   // The imbalance event always closes a snapshot
   a_imb_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tdata[CODE_W-1:0] == EV_IMB) ||
                      (rsp_tdata[CODE_W-1:0] == EV_IMB_CLR))) |-> rsp_tlast)
      else $error("imbalance event not last of snapshot");

   // With no event waiting, an offered snapshot is always taken
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !rsp_tvalid) |-> req_tready)
      else $error("input channel stuck");

endmodule

bind three_phase_voltage_event_detector tpved_checker u_tpved_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
